// ===== rtl/core/nmea_sentence_check_classify_macros.svh =====
// assertion macros shared by the rtl files
`ifndef NMEA_SENTENCE_CHECK_CLASSIFY_MACROS_SVH
`define NMEA_SENTENCE_CHECK_CLASSIFY_MACROS_SVH

// same-cycle implication, checked outside reset
`define NCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ncc_pkg.sv =====
package ncc_pkg;

    // character codes
    localparam logic [7:0] CH_START = 8'h24;    // '$'
    localparam logic [7:0] CH_STAR  = 8'h2A;    // '*'
    localparam logic [7:0] CH_PROP  = 8'h50;    // 'P'
    localparam logic [7:0] CH_NINE  = 8'h39;    // '9'
    localparam logic [7:0] CH_ZERO  = 8'h30;    // '0'
    localparam logic [7:0] CH_A_OFS = 8'h37;    // 'A' - 10

    // sentence positions
    localparam logic [3:0] POS_SAT     = 4'd8;
    localparam logic [3:0] POS_MIN_LEN = 4'd7;
    localparam int         HDR_DEPTH   = 5;

    // checksum digit counter
    localparam logic [1:0] DIGITS_NONE = 2'd0;
    localparam logic [1:0] DIGITS_ONE  = 2'd1;
    localparam logic [1:0] DIGITS_TWO  = 2'd2;

    // known type words
    localparam logic [31:0] TYPE_GGA   = {8'h00, "GGA"};
    localparam logic [31:0] TYPE_GSA   = {8'h00, "GSA"};
    localparam logic [31:0] TYPE_GSV   = {8'h00, "GSV"};
    localparam logic [31:0] TYPE_RMC   = {8'h00, "RMC"};
    localparam logic [31:0] TYPE_GLL   = {8'h00, "GLL"};
    localparam logic [31:0] TYPE_PGRMM = "GRMM";

    // type class codes
    localparam logic [2:0] CLASS_OTHER = 3'd0;
    localparam logic [2:0] CLASS_GGA   = 3'd1;
    localparam logic [2:0] CLASS_GSA   = 3'd2;
    localparam logic [2:0] CLASS_GSV   = 3'd3;
    localparam logic [2:0] CLASS_RMC   = 3'd4;
    localparam logic [2:0] CLASS_GLL   = 3'd5;
    localparam logic [2:0] CLASS_PGRMM = 3'd6;

    // status of the checksum tracker after the current beat
    typedef struct packed {
        logic star_seen;
        logic digits_done;
        logic sum_match;
    } t_chk_status;

    // loose hex decode: no character is rejected
    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else begin
            v = c - CH_A_OFS;
        end
        return v;
    endfunction

    function automatic logic [2:0] classify(input logic [31:0] w);
        logic [2:0] k;
        if (w == TYPE_GGA) begin
            k = CLASS_GGA;
        end else if (w == TYPE_GSA) begin
            k = CLASS_GSA;
        end else if (w == TYPE_GSV) begin
            k = CLASS_GSV;
        end else if (w == TYPE_RMC) begin
            k = CLASS_RMC;
        end else if (w == TYPE_GLL) begin
            k = CLASS_GLL;
        end else if (w == TYPE_PGRMM) begin
            k = CLASS_PGRMM;
        end else begin
            k = CLASS_OTHER;
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/ncc_if.sv =====
// sentence byte channel
interface ncc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sentence_byte;
    logic       last_byte;

    modport source (output valid, output sentence_byte, output last_byte, input ready);
    modport sink   (input valid, input sentence_byte, input last_byte, output ready);
endinterface

// result channel
interface ncc_out_if;
    logic        valid;
    logic        ready;
    logic        sentence_valid;
    logic [31:0] type_word;
    logic [2:0]  type_class;

    modport source (output valid, output sentence_valid, output type_word,
                    output type_class, input ready);
    modport sink   (input valid, input sentence_valid, input type_word,
                    input type_class, output ready);
endinterface

// ===== rtl/core/ncc_checksum.sv =====
`include "nmea_sentence_check_classify_macros.svh"

module ncc_checksum (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_beat,
    input  logic                 i_first,
    input  logic                 i_last,
    input  logic [7:0]           i_byte,
    output ncc_pkg::t_chk_status o_status
);

    logic       r_star_seen;
    logic [1:0] r_digits;
    logic [7:0] r_xor;
    logic [7:0] r_sum;

    logic       n_star_seen;
    logic [1:0] n_digits;
    logic [7:0] n_xor;
    logic [7:0] n_sum;
    logic [7:0] nib;

    assign nib = ncc_pkg::nibble_of(i_byte);

    // state after taking this byte (the start mark byte is skipped)
    always_comb begin
        n_star_seen = r_star_seen;
        n_digits    = r_digits;
        n_xor       = r_xor;
        n_sum       = r_sum;
        if (!i_first) begin
            if (!r_star_seen) begin
                if (i_byte == ncc_pkg::CH_STAR) begin
                    n_star_seen = 1'b1;
                end else begin
                    n_xor = r_xor ^ i_byte;
                end
            end else if (r_digits == ncc_pkg::DIGITS_NONE) begin
                n_sum    = {nib[3:0], 4'h0};
                n_digits = ncc_pkg::DIGITS_ONE;
            end else if (r_digits == ncc_pkg::DIGITS_ONE) begin
                n_sum    = r_sum + nib;
                n_digits = ncc_pkg::DIGITS_TWO;
            end
        end
    end

    assign o_status.star_seen   = n_star_seen;
    assign o_status.digits_done = (n_digits == ncc_pkg::DIGITS_TWO);
    assign o_status.sum_match   = (n_sum == n_xor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star_seen <= 1'b0;
            r_digits    <= ncc_pkg::DIGITS_NONE;
            r_xor       <= 8'h00;
            r_sum       <= 8'h00;
        end else if (i_beat) begin
            if (i_last) begin
                r_star_seen <= 1'b0;
                r_digits    <= ncc_pkg::DIGITS_NONE;
                r_xor       <= 8'h00;
                r_sum       <= 8'h00;
            end else begin
                r_star_seen <= n_star_seen;
                r_digits    <= n_digits;
                r_xor       <= n_xor;
                r_sum       <= n_sum;
            end
        end
    end

    `NCC_ASSERT_NOW(a_digits_range, 1'b1, r_digits != 2'd3, "checksum digit count out of range")
    `NCC_ASSERT_NOW(a_digits_need_star, r_digits != ncc_pkg::DIGITS_NONE, r_star_seen,
                    "checksum digits counted before separator")
    `NCC_ASSERT_NEXT(a_clear_on_last, i_beat && i_last,
                     !r_star_seen && r_digits == ncc_pkg::DIGITS_NONE && r_xor == 8'h00,
                     "checksum state not cleared after sentence end")

endmodule

// ===== rtl/core/nmea_sentence_check_classify.sv =====
// NMEA 0183 sentence checker and classifier. Bytes of a sentence arrive on
// i_byte_ch one beat at a time, last_byte set on the final beat; one beat is
// taken every cycle. The start mark '$' is checked, the bytes between it and
// the first '*' are XORed, and the two characters after the '*' are decoded
// as hex (loosely: no character is rejected) and compared with the XOR. On
// the final beat one result beat is produced on o_result_ch in the cycle
// after the byte is taken: sentence_valid, the packed type word (zero if
// invalid or 7 bytes or shorter) and the type class. The result is held in
// a single result register; throughput is one byte per cycle, and the
// byte channel stalls only while a result waits in that register and the
// sink holds ready low.
`include "nmea_sentence_check_classify_macros.svh"

module nmea_sentence_check_classify (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ncc_in_if.sink    i_byte_ch,
    ncc_out_if.source o_result_ch
);

    // byte position, saturating once past the header
    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       r_start_ok;
    logic       n_start_ok;

    // sentence bytes 1 to 5 (address letters)
    logic [7:0] r_hdr [ncc_pkg::HDR_DEPTH];

    // result register
    logic        r_out_valid;
    logic        r_sentence_valid;
    logic [31:0] r_type_word;
    logic [2:0]  r_type_class;

    logic                 in_beat;
    logic                 first;
    logic                 long_enough;
    logic                 sent_valid;
    logic                 word_en;
    logic [31:0]          raw_word;
    ncc_pkg::t_chk_status chk;

    // take a byte whenever the result register is free or being drained
    assign i_byte_ch.ready = !r_out_valid || o_result_ch.ready;
    assign in_beat         = i_byte_ch.valid && i_byte_ch.ready;
    assign first           = (r_pos == 4'd0);

    ncc_checksum u_checksum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (in_beat),
        .i_first  (first),
        .i_last   (i_byte_ch.last_byte),
        .i_byte   (i_byte_ch.sentence_byte),
        .o_status (chk)
    );

    assign n_start_ok = first ? (i_byte_ch.sentence_byte == ncc_pkg::CH_START) : r_start_ok;
    assign n_pos      = (r_pos < ncc_pkg::POS_SAT) ? r_pos + 4'd1 : r_pos;

    assign sent_valid  = n_start_ok && chk.star_seen && chk.digits_done && chk.sum_match;
    // a last byte at position 7 or beyond means the header is already stored
    assign long_enough = (r_pos >= ncc_pkg::POS_MIN_LEN);
    assign word_en     = sent_valid && long_enough;

    // proprietary sentences ('P' first) carry one more letter on top
    assign raw_word = {(r_hdr[0] == ncc_pkg::CH_PROP) ? r_hdr[1] : 8'h00,
                       r_hdr[2], r_hdr[3], r_hdr[4]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 4'd0;
            r_start_ok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                if (i_byte_ch.last_byte) begin
                    r_pos      <= 4'd0;
                    r_start_ok <= 1'b0;
                end else begin
                    r_pos      <= n_pos;
                    r_start_ok <= n_start_ok;
                end
            end
            if (in_beat && i_byte_ch.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // header capture; stale bytes from an earlier sentence are never read
    // because the word is used only when all five were written
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ncc_pkg::HDR_DEPTH; k++) begin
            if (in_beat && r_pos == 4'(k + 1)) begin
                r_hdr[k] <= i_byte_ch.sentence_byte;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_beat && i_byte_ch.last_byte) begin
            r_sentence_valid <= sent_valid;
            r_type_word      <= word_en ? raw_word : 32'h0;
            r_type_class     <= word_en ? ncc_pkg::classify(raw_word) : ncc_pkg::CLASS_OTHER;
        end
    end

    assign o_result_ch.valid          = r_out_valid;
    assign o_result_ch.sentence_valid = r_sentence_valid;
    assign o_result_ch.type_word      = r_type_word;
    assign o_result_ch.type_class     = r_type_class;

    `NCC_ASSERT_NOW(a_pos_range, 1'b1, r_pos <= ncc_pkg::POS_SAT, "byte position past saturation")
    `NCC_ASSERT_NOW(a_invalid_zero, r_out_valid && !r_sentence_valid,
                    r_type_word == 32'h0 && r_type_class == ncc_pkg::CLASS_OTHER,
                    "invalid sentence carries a type")
    `NCC_ASSERT_NOW(a_class_has_word, r_out_valid && r_type_class != ncc_pkg::CLASS_OTHER,
                    r_type_word != 32'h0, "type class without type word")
    `NCC_ASSERT_NEXT(a_restart_after_last, in_beat && i_byte_ch.last_byte,
                     r_pos == 4'd0 && r_out_valid, "no restart or no result after last beat")

endmodule
